>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CHBD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define CHBD_ASSERT(lbl, clk, rst_n, prop)
`define CHBD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/chbd_pkg.sv
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder package
// Field widths, action codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package chbd_pkg;

	localparam int unsigned VALUE_W = 31;
	localparam int unsigned FIRST_W = 17;
	localparam int unsigned SYM_W   = 16;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned INDEX_W = 16;

	typedef enum logic [1:0] {
		ACT_DECODE     = 2'd0,
		ACT_LOAD_MIN   = 2'd1,
		ACT_LOAD_FIRST = 2'd2,
		ACT_LOAD_SYM   = 2'd3
	} action_t;

	typedef struct packed {
		logic               is_write;
		logic [LEN_W-1:0]   len;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] minc;
		logic [FIRST_W-1:0] first;
		logic [INDEX_W-1:0] addr;
		logic [SYM_W-1:0]   data;
	} q_entry_t;

endpackage

>>> design/chbd_queue.sv
// ----------------------------------------------------------------------------
// Decoupling queue
// Two-entry queue that carries completed codes and symbol writes to the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chbd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  chbd_pkg::q_entry_t push_entry,
	input  logic               pop,
	output chbd_pkg::q_entry_t head,
	output logic               empty,
	output logic               full
);

	chbd_pkg::q_entry_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`CHBD_NEVER(a_no_push_full, clk, arst_n, push && full)
	`CHBD_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)

endmodule

>>> design/chbd_front.sv
// ----------------------------------------------------------------------------
// Decoder front
// Accepts beats, keeps the length tables and the partial code, and queues
// every completed code and every in-range symbol write for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chbd_front #(
	parameter int unsigned MAX_CODE_LEN = 32,
	parameter int unsigned SYMBOL_COUNT = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [1:0]                       action,
	input  logic                             bit_in,
	input  logic [chbd_pkg::INDEX_W-1:0]     table_index,
	input  logic [chbd_pkg::VALUE_W-1:0]     table_value,
	input  logic                             q_full,
	output logic                             q_push,
	output chbd_pkg::q_entry_t               q_entry
);

	localparam int unsigned LW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
	localparam int unsigned CAP = (MAX_CODE_LEN - 1 > 31) ? 31 : MAX_CODE_LEN - 1;
	localparam logic [chbd_pkg::LEN_W-1:0] LEN_CAP = chbd_pkg::LEN_W'(CAP);

	logic [chbd_pkg::VALUE_W-1:0] min_tbl_q   [MAX_CODE_LEN];
	logic [chbd_pkg::FIRST_W-1:0] first_tbl_q [MAX_CODE_LEN];
	logic [chbd_pkg::VALUE_W-1:0] pv_q;
	logic [chbd_pkg::LEN_W-1:0]   pl_q;

	chbd_pkg::action_t            act;
	logic                         accept;
	logic [chbd_pkg::LEN_W-1:0]   len_next;
	logic [chbd_pkg::VALUE_W-1:0] val_next;
	logic [chbd_pkg::VALUE_W-1:0] minc;
	logic [chbd_pkg::FIRST_W-1:0] first;
	logic                         complete;
	logic                         len_ok;
	logic                         slot_ok;

	assign act        = chbd_pkg::action_t'(action);
	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	assign len_next = pl_q + chbd_pkg::LEN_W'(1);
	assign val_next = {pv_q[chbd_pkg::VALUE_W-2:0], bit_in};
	assign minc     = min_tbl_q[len_next[LW-1:0]];
	assign first    = first_tbl_q[len_next[LW-1:0]];
	assign complete = (val_next >= minc) || (len_next >= LEN_CAP);

	assign len_ok  = ({1'b0, table_index} < 17'(MAX_CODE_LEN));
	assign slot_ok = ({9'b0, table_index} < 25'(SYMBOL_COUNT));

	always_comb begin
		q_push  = 1'b0;
		q_entry = '0;
		case (act)
			chbd_pkg::ACT_DECODE: begin
				q_push         = accept && complete;
				q_entry.len    = len_next;
				q_entry.value  = val_next;
				q_entry.minc   = minc;
				q_entry.first  = first;
			end
			chbd_pkg::ACT_LOAD_SYM: begin
				q_push           = accept && slot_ok;
				q_entry.is_write = 1'b1;
				q_entry.addr     = table_index;
				q_entry.data     = table_value[chbd_pkg::SYM_W-1:0];
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(MAX_CODE_LEN); i++) begin
				min_tbl_q[i]   <= '0;
				first_tbl_q[i] <= '0;
			end
			pv_q <= '0;
			pl_q <= '0;
		end else if (accept) begin
			case (act)
				chbd_pkg::ACT_DECODE: begin
					if (complete) begin
						pv_q <= '0;
						pl_q <= '0;
					end else begin
						pv_q <= val_next;
						pl_q <= len_next;
					end
				end
				chbd_pkg::ACT_LOAD_MIN: begin
					if (len_ok) begin
						min_tbl_q[table_index[LW-1:0]] <= table_value;
					end
				end
				chbd_pkg::ACT_LOAD_FIRST: begin
					if (len_ok) begin
						first_tbl_q[table_index[LW-1:0]] <=
							table_value[chbd_pkg::FIRST_W-1:0];
					end
				end
				default: begin
					pv_q <= pv_q;
				end
			endcase
		end
	end

	`CHBD_ASSERT(a_len_below_cap, clk, arst_n, pl_q < LEN_CAP)
	`CHBD_ASSERT(a_complete_resets, clk, arst_n,
		accept && act == chbd_pkg::ACT_DECODE && complete |=> pl_q == '0)

endmodule

>>> design/chbd_back.sv
// ----------------------------------------------------------------------------
// Decoder back
// Computes the symbol index, reads or writes the symbol memory and holds
// the result beat until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chbd_back #(
	parameter int unsigned SYMBOL_COUNT = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  chbd_pkg::q_entry_t             head,
	input  logic                           q_empty,
	output logic                           q_pop,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [chbd_pkg::SYM_W-1:0]     symbol,
	output logic [chbd_pkg::LEN_W-1:0]     code_length,
	output logic                           index_error
);

	localparam int unsigned SYM_DEPTH = (SYMBOL_COUNT > 65536) ? 65536 : SYMBOL_COUNT;
	localparam int unsigned SYM_AW = $clog2(SYM_DEPTH);

	logic [chbd_pkg::SYM_W-1:0] mem [SYM_DEPTH];

	logic [32:0]                sidx;
	logic                       err;
	logic                       pop_dec;
	logic                       pop_wr;
	logic                       valid_s1;
	logic [chbd_pkg::SYM_W-1:0] rd_s1;
	logic [chbd_pkg::LEN_W-1:0] len_s1;
	logic                       err_s1;

	assign sidx = 33'(head.first) + 33'(head.value) - 33'(head.minc);
	assign err  = sidx[32] || (sidx[31:0] >= 32'(SYMBOL_COUNT));

	assign q_pop   = !q_empty && (head.is_write || !valid_s1 || result_ready);
	assign pop_dec = q_pop && !head.is_write;
	assign pop_wr  = q_pop && head.is_write;

	always_ff @(posedge clk) begin
		if (pop_wr) begin
			mem[head.addr[SYM_AW-1:0]] <= head.data;
		end
		if (pop_dec) begin
			rd_s1  <= mem[sidx[SYM_AW-1:0]];
			len_s1 <= head.len;
			err_s1 <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop_dec) begin
			valid_s1 <= 1'b1;
		end else if (result_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign result_valid = valid_s1;
	assign symbol       = err_s1 ? '0 : rd_s1;
	assign code_length  = len_s1;
	assign index_error  = err_s1;

	`CHBD_ASSERT(a_decode_pop_valid, clk, arst_n, pop_dec |=> valid_s1)
	`CHBD_NEVER(a_no_overwrite, clk, arst_n, pop_dec && valid_s1 && !result_ready)

endmodule

>>> design/canonical_huffman_bit_decoder.sv
// A decode beat that completes a code passes through the queue and the result register.
// Throughput: one input beat per cycle while the queue is not full; the partial code
// compare closes the per-bit loop. Load beats give no result; symbol writes pass through
// the queue in order with decodes. Reset clears the length tables, the partial code and
// the queue; the symbol memory is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder
// Bit-serial decoder with a front that walks the code and a back that looks
// up symbols, joined by a two-entry queue.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder #(
	parameter int unsigned MAX_CODE_LEN = 32,
	parameter int unsigned SYMBOL_COUNT = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   action,
	input  logic                         bit_in,
	input  logic [chbd_pkg::INDEX_W-1:0] table_index,
	input  logic [chbd_pkg::VALUE_W-1:0] table_value,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [chbd_pkg::SYM_W-1:0]   symbol,
	output logic [chbd_pkg::LEN_W-1:0]   code_length,
	output logic                         index_error
);

	chbd_pkg::q_entry_t push_entry;
	chbd_pkg::q_entry_t head;
	logic               push;
	logic               pop;
	logic               empty;
	logic               full;

	chbd_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.action     (action),
		.bit_in     (bit_in),
		.table_index(table_index),
		.table_value(table_value),
		.q_full     (full),
		.q_push     (push),
		.q_entry    (push_entry)
	);

	chbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	chbd_back #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (empty),
		.q_pop       (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.symbol      (symbol),
		.code_length (code_length),
		.index_error (index_error)
	);

endmodule

>>> tb/sv/canonical_huffman_bit_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder checker
// Watches the item and result channels of the decoder. Every accepted item
// beat updates a private copy of the code tables and of the partial code, and
// a beat that completes a code queues the decoded symbol it should give. Each
// accepted result beat is compared field by field with the oldest queued code.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  logic [1:0]                   action,
	input  logic                         bit_in,
	input  logic [chbd_pkg::INDEX_W-1:0] table_index,
	input  logic [chbd_pkg::VALUE_W-1:0] table_value,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  logic [chbd_pkg::SYM_W-1:0]   symbol,
	input  logic [chbd_pkg::LEN_W-1:0]   code_length,
	input  logic                         index_error,
	output int unsigned                  failures,
	output int unsigned                  outstanding
);

	localparam int unsigned LEN_SLOTS = 32;
	localparam int unsigned SYM_SLOTS = 65536;
	localparam int unsigned LONGEST   = LEN_SLOTS - 1;

	typedef struct packed {
		logic [chbd_pkg::SYM_W-1:0] symbol;
		logic [chbd_pkg::LEN_W-1:0] len;
		logic                       err;
	} decoded_t;

	logic [chbd_pkg::VALUE_W-1:0] smallest_code [LEN_SLOTS];
	logic [chbd_pkg::FIRST_W-1:0] first_idx [LEN_SLOTS];
	logic [chbd_pkg::SYM_W-1:0]   sym_mem [SYM_SLOTS];
	logic [chbd_pkg::VALUE_W-1:0] code_value;
	logic [chbd_pkg::LEN_W-1:0]   code_len;
	decoded_t                     decoded_q [$];
	int unsigned                  fail_total = 0;

	assign failures = fail_total;

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t                     got;
		decoded_t                     want;
		logic [chbd_pkg::VALUE_W-1:0] next_value;
		logic [chbd_pkg::LEN_W-1:0]   next_len;
		longint                       slot;
		if (!arst_n) begin
			foreach (smallest_code[i]) begin
				smallest_code[i] = '0;
				first_idx[i]     = '0;
			end
			code_value = '0;
			code_len   = '0;
			decoded_q.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				got = '{symbol, code_length, index_error};
				if (decoded_q.size() == 0) begin
					$error("result beat with no code waiting: symbol %0h, code_length %0d",
						got.symbol, got.len);
					fail_total++;
				end else begin
					want = decoded_q.pop_front();
					if (got.symbol !== want.symbol) begin
						$error("symbol: expected %0h, actual %0h", want.symbol, got.symbol);
						fail_total++;
					end
					if (got.len !== want.len) begin
						$error("code_length: expected %0d, actual %0d", want.len, got.len);
						fail_total++;
					end
					if (got.err !== want.err) begin
						$error("index_error: expected %0b, actual %0b", want.err, got.err);
						fail_total++;
					end
				end
			end
			if (item_valid && item_ready) begin
				case (action)
					chbd_pkg::ACT_LOAD_MIN: begin
						if (table_index < LEN_SLOTS)
							smallest_code[table_index[chbd_pkg::LEN_W-1:0]] = table_value;
					end
					chbd_pkg::ACT_LOAD_FIRST: begin
						if (table_index < LEN_SLOTS)
							first_idx[table_index[chbd_pkg::LEN_W-1:0]] =
								table_value[chbd_pkg::FIRST_W-1:0];
					end
					chbd_pkg::ACT_LOAD_SYM: begin
						sym_mem[table_index] = table_value[chbd_pkg::SYM_W-1:0];
					end
					default: begin
						next_value = {code_value[chbd_pkg::VALUE_W-2:0], bit_in};
						next_len   = code_len + chbd_pkg::LEN_W'(1);
						if (next_value >= smallest_code[next_len] || next_len >= LONGEST) begin
							slot = longint'(first_idx[next_len]) + longint'(next_value)
								- longint'(smallest_code[next_len]);
							want.len    = next_len;
							want.err    = (slot < 0) || (slot >= SYM_SLOTS);
							want.symbol = want.err ? '0 : sym_mem[slot[chbd_pkg::INDEX_W-1:0]];
							decoded_q.push_back(want);
							code_value = '0;
							code_len   = '0;
						end else begin
							code_value = next_value;
							code_len   = next_len;
						end
					end
				endcase
			end
			outstanding <= decoded_q.size();
		end
	end

endmodule

>>> tb/sv/canonical_huffman_bit_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder testbench
// Drives load and decode beats into the decoder: a directed opening, then
// phases with complete canonical codes, random tables and codes forced to
// the longest length. A shadow of the tables keeps every symbol lookup on a
// written slot. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_tb;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned LEN_SLOTS   = 32;
	localparam int unsigned SYM_SLOTS   = 65536;
	localparam int unsigned LONGEST     = LEN_SLOTS - 1;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         item_valid = 1'b0;
	logic                         item_ready;
	logic [1:0]                   action = chbd_pkg::ACT_DECODE;
	logic                         bit_in = 1'b0;
	logic [chbd_pkg::INDEX_W-1:0] table_index = '0;
	logic [chbd_pkg::VALUE_W-1:0] table_value = '0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic [chbd_pkg::SYM_W-1:0]   symbol;
	logic [chbd_pkg::LEN_W-1:0]   code_length;
	logic                         index_error;
	int unsigned                  failures;
	int unsigned                  outstanding;

	bit                           tx_idle = 1'b1;
	bit                           rx_idle = 1'b1;
	bit                           squeeze_req = 1'b0;
	bit                           squeeze_done = 1'b0;
	int unsigned                  cycle_count = 0;

	logic [chbd_pkg::VALUE_W-1:0] sh_min [LEN_SLOTS];
	logic [chbd_pkg::FIRST_W-1:0] sh_first [LEN_SLOTS];
	bit                           sym_written [SYM_SLOTS];
	logic [chbd_pkg::VALUE_W-1:0] sh_value = '0;
	logic [chbd_pkg::LEN_W-1:0]   sh_len = '0;

	always #5 clk = ~clk;

	canonical_huffman_bit_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.bit_in       (bit_in),
		.table_index  (table_index),
		.table_value  (table_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.symbol       (symbol),
		.code_length  (code_length),
		.index_error  (index_error)
	);

	canonical_huffman_bit_decoder_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.bit_in       (bit_in),
		.table_index  (table_index),
		.table_value  (table_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.symbol       (symbol),
		.code_length  (code_length),
		.index_error  (index_error),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** canonical_huffman_bit_decoder: FAILED **");
			$finish;
		end
	end

	// The long hold-off lets the two-entry queue fill so that the item side stalls.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				result_ready <= 1'b0;
				repeat (399) @(negedge clk);
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic beat(chbd_pkg::action_t act, logic b, logic [chbd_pkg::INDEX_W-1:0] idx,
		logic [chbd_pkg::VALUE_W-1:0] val);
		case (act)
			chbd_pkg::ACT_LOAD_MIN:
				if (idx < LEN_SLOTS) sh_min[idx[chbd_pkg::LEN_W-1:0]] = val;
			chbd_pkg::ACT_LOAD_FIRST:
				if (idx < LEN_SLOTS)
					sh_first[idx[chbd_pkg::LEN_W-1:0]] = val[chbd_pkg::FIRST_W-1:0];
			chbd_pkg::ACT_LOAD_SYM:
				sym_written[idx] = 1'b1;
			default: ;
		endcase
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		item_valid  <= 1'b1;
		action      <= act;
		bit_in      <= b;
		table_index <= idx;
		table_value <= val;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	// A code that would look up a slot never written gets that slot loaded first.
	task automatic decode(logic b);
		logic [chbd_pkg::VALUE_W-1:0] next_value;
		logic [chbd_pkg::LEN_W-1:0]   next_len;
		longint                       slot;
		next_value = {sh_value[chbd_pkg::VALUE_W-2:0], b};
		next_len   = sh_len + chbd_pkg::LEN_W'(1);
		if (next_value >= sh_min[next_len] || next_len >= LONGEST) begin
			slot = longint'(sh_first[next_len]) + longint'(next_value)
				- longint'(sh_min[next_len]);
			if (slot >= 0 && slot < SYM_SLOTS && !sym_written[slot])
				beat(chbd_pkg::ACT_LOAD_SYM, 1'($urandom), slot[chbd_pkg::INDEX_W-1:0],
					31'($urandom));
			sh_value = '0;
			sh_len   = '0;
		end else begin
			sh_value = next_value;
			sh_len   = next_len;
		end
		beat(chbd_pkg::ACT_DECODE, b, 16'($urandom), 31'($urandom));
	endtask

	task automatic load_canonical();
		int unsigned                  count [LEN_SLOTS];
		logic [chbd_pkg::VALUE_W-1:0] minc [LEN_SLOTS];
		logic [chbd_pkg::FIRST_W-1:0] start [LEN_SLOTS];
		int unsigned                  depth;
		int unsigned                  avail;
		int unsigned                  total;
		int unsigned                  base;
		int unsigned                  running;
		foreach (count[l]) begin
			count[l] = 0;
			minc[l]  = '0;
		end
		depth = $urandom_range(1, 6);
		avail = 2;
		total = 0;
		for (int l = 1; l <= depth; l++) begin
			count[l] = (l == depth) ? avail : $urandom_range(avail / 2, avail);
			total += count[l];
			if (count[l] == avail) begin
				depth = l;
				break;
			end
			avail = (avail - count[l]) * 2;
		end
		for (int l = depth - 1; l >= 1; l--)
			minc[l] = 31'((minc[l + 1] + count[l + 1] + 1) / 2);
		minc[0] = 31'($urandom);
		base = $urandom_range(0, 2) == 0 ? SYM_SLOTS - total : $urandom_range(0, SYM_SLOTS - total);
		running = base;
		start[0] = 17'($urandom);
		for (int l = 1; l < LEN_SLOTS; l++) begin
			start[l] = 17'(running);
			running += count[l];
		end
		for (int l = 0; l < LEN_SLOTS; l++) begin
			beat(chbd_pkg::ACT_LOAD_MIN, 1'($urandom), 16'(l), minc[l]);
			beat(chbd_pkg::ACT_LOAD_FIRST, 1'($urandom), 16'(l), {14'($urandom), start[l]});
		end
		for (int s = 0; s < total; s++)
			beat(chbd_pkg::ACT_LOAD_SYM, 1'($urandom), 16'(base + s), 31'($urandom));
	endtask

	task automatic load_random_tables();
		logic [chbd_pkg::FIRST_W-1:0] start;
		for (int l = 0; l < LEN_SLOTS; l++) begin
			start = $urandom_range(0, 1) ? 17'($urandom_range(0, 1000)) : 17'($urandom);
			beat(chbd_pkg::ACT_LOAD_MIN, 1'($urandom), 16'(l),
				31'($urandom) >> (chbd_pkg::VALUE_W - l));
			beat(chbd_pkg::ACT_LOAD_FIRST, 1'($urandom), 16'(l), {14'($urandom), start});
		end
	endtask

	// Every length but the longest is out of reach, so each code runs to the cap.
	task automatic long_codes();
		logic [chbd_pkg::VALUE_W-1:0] tail_min [3];
		logic [chbd_pkg::FIRST_W-1:0] tail_first [3];
		tail_min   = '{31'h7FFF_FFFF, 31'h0, 31'($urandom)};
		tail_first = '{17'($urandom), 17'h1_FFFF, 17'($urandom)};
		for (int l = 1; l < LONGEST; l++)
			beat(chbd_pkg::ACT_LOAD_MIN, 1'($urandom), 16'(l), 31'h7FFF_FFFF);
		for (int c = 0; c < 3; c++) begin
			beat(chbd_pkg::ACT_LOAD_MIN, 1'($urandom), 16'(LONGEST), tail_min[c]);
			beat(chbd_pkg::ACT_LOAD_FIRST, 1'($urandom), 16'(LONGEST),
				{14'($urandom), tail_first[c]});
			repeat (LONGEST) decode(1'($urandom));
		end
	endtask

	task automatic bit_stream(int unsigned n, bit table_noise);
		int unsigned pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				beat(chbd_pkg::action_t'($urandom_range(1, 2)), 1'($urandom),
					16'($urandom_range(LEN_SLOTS, 65535)), 31'($urandom));
			else if (pick == 1)
				beat(chbd_pkg::ACT_LOAD_SYM, 1'($urandom), 16'($urandom), 31'($urandom));
			else if (pick == 2 && table_noise)
				beat(chbd_pkg::action_t'($urandom_range(1, 2)), 1'($urandom),
					16'($urandom_range(1, LONGEST)), 31'($urandom) >> $urandom_range(0, 30));
			else
				decode(1'($urandom));
		end
	endtask

	initial begin : stimulus
		foreach (sh_min[l]) begin
			sh_min[l]   = '0;
			sh_first[l] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		beat(chbd_pkg::ACT_LOAD_SYM, 1'b0, 16'h0000, 31'h7FFF_FFFF);
		beat(chbd_pkg::ACT_LOAD_SYM, 1'b1, 16'hFFFF, 31'h0);
		decode(1'b0);
		decode(1'b1);
		beat(chbd_pkg::ACT_LOAD_MIN, 1'b0, 16'hFFFF, 31'h7FFF_FFFF);
		beat(chbd_pkg::ACT_LOAD_FIRST, 1'b1, 16'd32, 31'h7FFF_FFFF);
		beat(chbd_pkg::ACT_LOAD_FIRST, 1'b0, 16'd1, 31'h0000_FFFF);
		decode(1'b0);
		decode(1'b1);
		beat(chbd_pkg::ACT_LOAD_FIRST, 1'b0, 16'd1, 31'h7FFF_FFFF);
		decode(1'b1);
		beat(chbd_pkg::ACT_LOAD_MIN, 1'b0, 16'd1, 31'h1);
		beat(chbd_pkg::ACT_LOAD_FIRST, 1'b0, 16'd1, 31'h0);
		decode(1'b1);
		decode(1'b0);
		beat(chbd_pkg::ACT_LOAD_MIN, 1'b1, 16'd2, 31'h0);
		beat(chbd_pkg::ACT_LOAD_FIRST, 1'b0, 16'd2, 31'h5);
		decode(1'b1);
		beat(chbd_pkg::ACT_LOAD_MIN, 1'b0, 16'd0, 31'h7FFF_FFFF);

		load_canonical();
		squeeze_req = 1'b1;
		bit_stream(100, 1'b0);
		load_random_tables();
		bit_stream(100, 1'b1);
		long_codes();
		load_canonical();
		bit_stream(100, 1'b0);
		load_random_tables();
		bit_stream(100, 1'b1);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		load_canonical();
		bit_stream(100, 1'b0);
		item_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("** canonical_huffman_bit_decoder: PASSED **");
		else
			$display("** canonical_huffman_bit_decoder: FAILED **");
		$finish;
	end

endmodule
